FILE: hdl/tfv_pkg.sv
// Package for the text field validator: payload, result, configuration and field state types.
// Shared constants and codes. No dependencies.
package tfv_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int LEN_OUT_W   = 16;
    localparam int CMP_W       = (LENGTH_BITS > LEN_OUT_W) ? LENGTH_BITS : LEN_OUT_W;
    localparam int CFG_W       = 16;
    localparam int CP_W        = 21;

    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MIN_TWO   = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN_THREE = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN_FOUR  = 21'h010000;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_LEN  = 2'd1,
        STATUS_BAD_UTF8 = 2'd2,
        STATUS_BAD_CHAR = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CS_PRINTABLE  = 2'd0,
        CS_ALNUM      = 2'd1,
        CS_IDENTIFIER = 2'd2,
        CS_ANY        = 2'd3
    } charset_t;

    typedef enum logic [1:0] {
        REG_MIN_LENGTH   = 2'd0,
        REG_MAX_LENGTH   = 2'd1,
        REG_CHARSET_MODE = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       no_bytes;
    } item_t;

    typedef struct packed {
        status_t                status;
        logic [LEN_OUT_W-1:0]   field_length;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] min_length;
        logic [CFG_W-1:0] max_length;
        charset_t         charset_mode;
    } cfg_t;

    typedef struct packed {
        logic [LENGTH_BITS-1:0] byte_count;
        logic [1:0]             pending;
        logic [1:0]             seq_extra;
        logic [CP_W-1:0]        partial_cp;
        logic                   enc_err;
        logic                   char_err;
    } field_t;

endpackage

FILE: hdl/tfv_step.sv
// Per-byte field update: length count, strict UTF-8 decode, charset check, status.
// Depends on tfv_pkg.
module tfv_step (
    input  tfv_pkg::field_t  field,
    input  tfv_pkg::item_t   item,
    input  tfv_pkg::cfg_t    cfg,
    output tfv_pkg::field_t  field_next,
    output logic             emit,
    output tfv_pkg::result_t res
);
    import tfv_pkg::*;

    logic [7:0]      b;
    field_t          upd;
    logic [CP_W-1:0] cp_cont;
    logic            bad_cp;
    logic            alnum;
    logic            allowed;
    logic            enc_final;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] min_ext;
    logic [CMP_W-1:0] max_ext;

    assign b       = item.data_byte;
    assign cp_cont = {field.partial_cp[CP_W-7:0], b[5:0]};
    assign alnum   = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A)
                  || (b >= 8'h61 && b <= 8'h7A);

    always_comb
    begin
        case (cfg.charset_mode)
            CS_PRINTABLE:  allowed = (b == 8'h09) || (b >= 8'h20 && b != 8'h7F);
            CS_ALNUM:      allowed = alnum;
            CS_IDENTIFIER: allowed = alnum || b == 8'h2E || b == 8'h5F || b == 8'h2D;
            CS_ANY:        allowed = 1'b1;
            default:       allowed = 1'b1;
        endcase
    end

    always_comb
    begin
        bad_cp = 1'b0;
        if (field.seq_extra == 2'd1 && cp_cont < CP_MIN_TWO)   bad_cp = 1'b1;
        if (field.seq_extra == 2'd2 && cp_cont < CP_MIN_THREE) bad_cp = 1'b1;
        if (field.seq_extra == 2'd3 && cp_cont < CP_MIN_FOUR)  bad_cp = 1'b1;
        if (cp_cont > CP_MAX)                                  bad_cp = 1'b1;
        if (cp_cont >= CP_SURR_LO && cp_cont <= CP_SURR_HI)    bad_cp = 1'b1;
    end

    always_comb
    begin
        upd = field;
        if (!item.no_bytes)
        begin
            if (field.byte_count != '1)
                upd.byte_count = field.byte_count + LENGTH_BITS'(1);
            if (field.pending != 2'd0)
            begin
                if (b[7:6] != 2'b10)
                begin
                    upd.enc_err    = 1'b1;
                    upd.pending    = 2'd0;
                    upd.seq_extra  = 2'd0;
                    upd.partial_cp = '0;
                end
                else if (field.pending == 2'd1)
                begin
                    upd.pending    = 2'd0;
                    upd.seq_extra  = 2'd0;
                    upd.partial_cp = '0;
                    if (bad_cp)
                        upd.enc_err = 1'b1;
                end
                else
                begin
                    upd.pending    = field.pending - 2'd1;
                    upd.partial_cp = cp_cont;
                end
            end
            else if (!b[7])
            begin
                if (!allowed)
                    upd.char_err = 1'b1;
            end
            else if (b[7:5] == 3'b110)
            begin
                upd.seq_extra  = 2'd1;
                upd.pending    = 2'd1;
                upd.partial_cp = CP_W'(b[4:0]);
            end
            else if (b[7:4] == 4'b1110)
            begin
                upd.seq_extra  = 2'd2;
                upd.pending    = 2'd2;
                upd.partial_cp = CP_W'(b[3:0]);
            end
            else if (b[7:3] == 5'b11110)
            begin
                upd.seq_extra  = 2'd3;
                upd.pending    = 2'd3;
                upd.partial_cp = CP_W'(b[2:0]);
            end
            else
            begin
                upd.enc_err = 1'b1;
            end
        end
    end

    assign emit      = item.last || item.no_bytes;
    assign enc_final = upd.enc_err || (upd.pending != 2'd0);
    assign cnt_ext   = CMP_W'(upd.byte_count);
    assign min_ext   = CMP_W'(cfg.min_length);
    assign max_ext   = CMP_W'(cfg.max_length);

    always_comb
    begin
        if (cnt_ext < min_ext || cnt_ext > max_ext)
            res.status = STATUS_BAD_LEN;
        else if (enc_final)
            res.status = STATUS_BAD_UTF8;
        else if (upd.char_err)
            res.status = STATUS_BAD_CHAR;
        else
            res.status = STATUS_OK;
        if (cnt_ext > CMP_W'({LEN_OUT_W{1'b1}}))
            res.field_length = '1;
        else
            res.field_length = cnt_ext[LEN_OUT_W-1:0];
    end

    assign field_next = emit ? '0 : upd;

endmodule

FILE: hdl/tfv_result_queue.sv
// Two-entry result queue between the decode logic and the output channel.
// Depends on tfv_pkg.
module tfv_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tfv_pkg::result_t push_data,
    output logic             full,
    output logic             valid,
    input  logic             stall,
    output tfv_pkg::result_t head
);
    import tfv_pkg::*;

    result_t    e0_reg;
    result_t    e1_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;

    assign valid = (cnt_reg != 2'd0);
    assign full  = (cnt_reg == 2'd2);
    assign pop   = valid && !stall;
    assign head  = e0_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (push && !pop)
        begin
            if (cnt_reg == 2'd0)
                e0_reg <= push_data;
            else
                e1_reg <= push_data;
        end
        else if (pop && !push)
        begin
            e0_reg <= e1_reg;
        end
        else if (pop && push)
        begin
            if (cnt_reg == 2'd1)
                e0_reg <= push_data;
            else
            begin
                e0_reg <= e1_reg;
                e1_reg <= push_data;
            end
        end
    end

endmodule

FILE: hdl/text_field_validator_top.sv
// Top level of the text field validator: config registers, field state, result queue.
// Depends on tfv_pkg, tfv_step and tfv_result_queue.
//
// Takes one byte of a text field per cycle while the input is not stalled, and gives
// one status and length per field. A result is registered in the result queue and
// at the earliest shows on the output in the cycle after the request carrying last
// or no_bytes is accepted, behind any results still queued. The input stalls
// exactly while both entries of the two-entry result queue are occupied.
// Configuration writes take effect on the next byte; there is no clearing pass.
module text_field_validator_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  tfv_pkg::item_t             item,
    output logic                       result_valid,
    input  logic                       result_stall,
    output tfv_pkg::result_t           result,
    input  logic                       cfg_write,
    input  logic [1:0]                 cfg_index,
    input  logic [tfv_pkg::CFG_W-1:0]  cfg_data
);
    import tfv_pkg::*;

    cfg_t    cfg_reg;
    field_t  field_reg;
    field_t  field_next;
    logic    emit;
    result_t step_res;
    logic    accept;
    logic    q_full;

    assign accept     = item_valid && !item_stall;
    assign item_stall = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_length   <= '0;
            cfg_reg.max_length   <= '1;
            cfg_reg.charset_mode <= CS_PRINTABLE;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_MIN_LENGTH:   cfg_reg.min_length   <= cfg_data;
                REG_MAX_LENGTH:   cfg_reg.max_length   <= cfg_data;
                REG_CHARSET_MODE: cfg_reg.charset_mode <= charset_t'(cfg_data[1:0]);
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    tfv_step u_step (
        .field      (field_reg),
        .item       (item),
        .cfg        (cfg_reg),
        .field_next (field_next),
        .emit       (emit),
        .res        (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            field_reg <= '0;
        else if (accept)
            field_reg <= field_next;
    end

    tfv_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && emit),
        .push_data (step_res),
        .full      (q_full),
        .valid     (result_valid),
        .stall     (result_stall),
        .head      (result)
    );

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("input stalled with no result held");

    a_field_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.last || item.no_bytes) |=>
            field_reg.byte_count == '0 && field_reg.pending == 2'd0
            && !field_reg.enc_err && !field_reg.char_err)
        else $error("field state not cleared after field end");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        field_reg.pending <= field_reg.seq_extra)
        else $error("pending continuations exceed sequence length");

    a_result_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.last || item.no_bytes) |=> result_valid)
        else $error("field end produced no result");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for text_field_validator_top: per-byte UTF-8, charset and length checks.
// Depends on tfv_pkg and the RTL under hdl; predicts every field status internally.
module testbench;
    import tfv_pkg::*;

    localparam int CLK_PERIOD = 12;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_stall;
    item_t            item;
    logic             result_valid;
    logic             result_stall;
    result_t          result;
    logic             cfg_write;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    text_field_validator_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    logic [15:0]            lim_lo;
    logic [15:0]            lim_hi;
    charset_t               ascii_mode;
    logic [LEN_OUT_W-1:0]   fld_count;
    logic [1:0]             fld_pending;
    logic [1:0]             fld_extra;
    logic [CP_W-1:0]        fld_cp;
    logic                   fld_enc_err;
    logic                   fld_char_err;

    result_t                expected_verdicts[$];
    logic [7:0]             field_bytes[$];
    int                     errors = 0;
    int                     requests_sent = 0;
    bit                     quiet = 1'b0;
    int                     hold_req = 0;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(CLK_PERIOD * 2_000_000);
        $display("FAIL");
        $finish;
    end

    function automatic bit ascii_permitted(input logic [7:0] b);
        bit alnum;
        alnum = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
                (b >= 8'h61 && b <= 8'h7A);
        case (ascii_mode)
            CS_PRINTABLE:  return b == 8'h09 || (b >= 8'h20 && b != 8'h7F);
            CS_ALNUM:      return alnum;
            CS_IDENTIFIER: return alnum || b == 8'h2E || b == 8'h5F || b == 8'h2D;
            default:       return 1'b1;
        endcase
    endfunction

    task automatic clear_field_state();
        fld_count    = '0;
        fld_pending  = '0;
        fld_extra    = '0;
        fld_cp       = '0;
        fld_enc_err  = 1'b0;
        fld_char_err = 1'b0;
    endtask

    task automatic close_codepoint();
        if (fld_extra == 2'd1 && fld_cp < CP_MIN_TWO) fld_enc_err = 1'b1;
        if (fld_extra == 2'd2 && fld_cp < CP_MIN_THREE) fld_enc_err = 1'b1;
        if (fld_extra == 2'd3 && fld_cp < CP_MIN_FOUR) fld_enc_err = 1'b1;
        if (fld_cp > CP_MAX) fld_enc_err = 1'b1;
        if (fld_cp >= CP_SURR_LO && fld_cp <= CP_SURR_HI) fld_enc_err = 1'b1;
        fld_extra = '0;
        fld_cp    = '0;
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        if (fld_count != '1) fld_count = fld_count + LEN_OUT_W'(1);
        if (fld_pending != 2'd0)
        begin
            if (b[7:6] != 2'b10)
            begin
                fld_enc_err = 1'b1;
                fld_pending = '0;
                fld_extra   = '0;
                fld_cp      = '0;
            end
            else
            begin
                fld_cp      = {fld_cp[14:0], b[5:0]};
                fld_pending = fld_pending - 2'd1;
                if (fld_pending == 2'd0) close_codepoint();
            end
        end
        else
        begin
            if (b < 8'h80)
            begin
                if (!ascii_permitted(b)) fld_char_err = 1'b1;
            end
            else if (b[7:5] == 3'b110)
            begin
                fld_extra = 2'd1;
                fld_cp    = CP_W'(b[4:0]);
            end
            else if (b[7:4] == 4'b1110)
            begin
                fld_extra = 2'd2;
                fld_cp    = CP_W'(b[3:0]);
            end
            else if (b[7:3] == 5'b11110)
            begin
                fld_extra = 2'd3;
                fld_cp    = CP_W'(b[2:0]);
            end
            else
            begin
                fld_enc_err = 1'b1;
            end
            fld_pending = fld_extra;
        end
    endtask

    task automatic predict_request(input item_t req);
        result_t verdict;
        if (!req.no_bytes) absorb_byte(req.data_byte);
        if (req.last || req.no_bytes)
        begin
            if (fld_pending != 2'd0) fld_enc_err = 1'b1;
            if (fld_count < lim_lo || fld_count > lim_hi) verdict.status = STATUS_BAD_LEN;
            else if (fld_enc_err) verdict.status = STATUS_BAD_UTF8;
            else if (fld_char_err) verdict.status = STATUS_BAD_CHAR;
            else verdict.status = STATUS_OK;
            verdict.field_length = fld_count;
            expected_verdicts.insert(expected_verdicts.size(), verdict);
            clear_field_state();
        end
    endtask

    task automatic send_request(input logic [7:0] b, input logic is_last, input logic is_empty);
        item_t req;
        req = '{data_byte: b, last: is_last, no_bytes: is_empty};
        if (!quiet && $urandom_range(99) < 22)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= req;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        predict_request(req);
        requests_sent++;
    endtask

    task automatic await_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_verdicts.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input reg_index_t idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_MIN_LENGTH:   lim_lo = val;
            REG_MAX_LENGTH:   lim_hi = val;
            REG_CHARSET_MODE: ascii_mode = charset_t'(val[1:0]);
            default:          ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] lo, input logic [15:0] hi,
                                  input charset_t mode);
        await_results();
        write_register(REG_MIN_LENGTH, lo);
        write_register(REG_MAX_LENGTH, hi);
        write_register(REG_CHARSET_MODE, CFG_W'(mode));
        cfg_write <= 1'b0;
    endtask

    task automatic send_field(input bit allow_empty_end);
        if (field_bytes.size() == 0)
        begin
            send_request(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        end
        else if (allow_empty_end && $urandom_range(99) < 12)
        begin
            foreach (field_bytes[i]) send_request(field_bytes[i], 1'b0, 1'b0);
            send_request(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        end
        else
        begin
            foreach (field_bytes[i])
                send_request(field_bytes[i], i == field_bytes.size() - 1, 1'b0);
        end
    endtask

    task automatic add_byte(input logic [7:0] b);
        field_bytes.insert(field_bytes.size(), b);
    endtask

    task automatic push_encoded(input logic [CP_W-1:0] cp, input int n);
        case (n)
            2:
            begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3:
            begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default:
            begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endtask

    function automatic logic [CP_W-1:0] legal_codepoint(input int n);
        case (n)
            2:       return CP_W'($urandom_range('h7FF, 'h80));
            3:       return CP_W'($urandom_range('hFFFF, 'h800));
            default: return CP_W'($urandom_range('h10FFFF, 'h10000));
        endcase
    endfunction

    function automatic logic [7:0] pick_ascii();
        case ($urandom_range(5))
            0: return 8'($urandom_range('h39, 'h30));
            1: return 8'($urandom_range('h5A, 'h41));
            2: return 8'($urandom_range('h7A, 'h61));
            3:
            begin
                case ($urandom_range(2))
                    0:       return 8'h2E;
                    1:       return 8'h5F;
                    default: return 8'h2D;
                endcase
            end
            default: return 8'($urandom_range(127));
        endcase
    endfunction

    task automatic build_field();
        int pick;
        int n;
        field_bytes.delete();
        repeat ($urandom_range(6))
        begin
            pick = $urandom_range(99);
            n    = $urandom_range(4, 2);
            if (pick < 40) add_byte(pick_ascii());
            else if (pick < 55) push_encoded(legal_codepoint(2), 2);
            else if (pick < 67) push_encoded(legal_codepoint(3), 3);
            else if (pick < 70) push_encoded(CP_W'($urandom_range('hDFFF, 'hD800)), 3);
            else if (pick < 78) push_encoded(legal_codepoint(4), 4);
            else if (pick < 81) push_encoded(CP_W'($urandom_range('h1FFFFF, 'h110000)), 4);
            else if (pick < 86)
                push_encoded(CP_W'($urandom_range(n == 2 ? 'h7F : n == 3 ? 'h7FF : 'hFFFF)),
                             n);
            else if (pick < 90)
            begin
                push_encoded(legal_codepoint(n), n);
                repeat ($urandom_range(n - 1, 1)) void'(field_bytes.pop_back());
            end
            else if (pick < 94) add_byte(8'($urandom_range('hBF, 'h80)));
            else if (pick < 97) add_byte(8'($urandom_range('hFF, 'hF8)));
            else add_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic run_phase(input logic [15:0] lo, input logic [15:0] hi,
                             input charset_t mode, input int target);
        int start;
        apply_settings(lo, hi, mode);
        start = requests_sent;
        while (requests_sent - start < target)
        begin
            build_field();
            send_field(1'b1);
            if ($urandom_range(99) < 3) await_results();
        end
    endtask

    task automatic test_decoding();
        apply_settings(16'd0, 16'hFFFF, CS_PRINTABLE);
        send_request(8'hFF, 1'b0, 1'b1);
        field_bytes = '{8'h09, 8'h7E};              send_field(1'b0);
        field_bytes = '{8'h7F};                     send_field(1'b0);
        field_bytes = '{8'hC2, 8'h80};              send_field(1'b0);
        field_bytes = '{8'hC1, 8'hBF};              send_field(1'b0);
        field_bytes = '{8'hED, 8'hA0, 8'h80};       send_field(1'b0);
        field_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; send_field(1'b0);
        field_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80}; send_field(1'b0);
        field_bytes = '{8'h80};                     send_field(1'b0);
        field_bytes = '{8'hF8};                     send_field(1'b0);
        field_bytes = '{8'hE2, 8'h82};              send_field(1'b0);
        field_bytes = '{8'hC3, 8'h41};              send_field(1'b0);
        send_request(8'h41, 1'b0, 1'b0);
        send_request(8'h00, 1'b1, 1'b1);
    endtask

    task automatic test_length_rules();
        apply_settings(16'd0, 16'd0, CS_ANY);
        send_request(8'h00, 1'b1, 1'b1);
        send_request(8'h78, 1'b1, 1'b0);
        apply_settings(16'd3, 16'd3, CS_PRINTABLE);
        field_bytes = '{8'h80, 8'h00, 8'h41}; send_field(1'b0);
        field_bytes = '{8'h80};               send_field(1'b0);
        apply_settings(16'd5, 16'd2, CS_ANY);
        field_bytes = '{8'h41, 8'h42, 8'h43}; send_field(1'b0);
    endtask

    task automatic test_backpressure();
        apply_settings(16'd0, 16'hFFFF, CS_PRINTABLE);
        quiet    = 1'b1;
        hold_req = 200;
        repeat (40) send_request(pick_ascii(), 1'b1, 1'b0);
        quiet = 1'b0;
        await_results();
    endtask

    task automatic test_random_phases();
        run_phase(16'd0, 16'hFFFF, CS_PRINTABLE, 250);
        run_phase(16'd2, 16'd9, CS_ALNUM, 250);
        run_phase(16'd1, 16'd12, CS_IDENTIFIER, 250);
        quiet = 1'b1;
        run_phase(16'd0, 16'hFFFF, CS_ANY, 250);
        quiet = 1'b0;
        run_phase(16'd7, 16'd3, charset_t'(2'($urandom_range(3))), 100);
        run_phase(16'($urandom_range(4)), 16'($urandom_range(14, 3)),
                  charset_t'(2'($urandom_range(3))), 180);
    endtask

    initial
    begin
        int hold_left;
        hold_left = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                result_stall <= !quiet && ($urandom_range(99) < 18);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result status %0d length %0d", $time,
                         result.status, result.field_length);
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (result.status !== want.status)
                begin
                    errors++;
                    $display("%0t: status mismatch expected %0d actual %0d", $time,
                             want.status, result.status);
                end
                if (result.field_length !== want.field_length)
                begin
                    errors++;
                    $display("%0t: length mismatch expected %0d actual %0d", $time,
                             want.field_length, result.field_length);
                end
            end
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        cfg_write  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        lim_lo     = 16'd0;
        lim_hi     = 16'hFFFF;
        ascii_mode = CS_PRINTABLE;
        clear_field_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_decoding();
        test_length_rules();
        test_backpressure();
        test_random_phases();
        await_results();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/tfv_pkg.sv
hdl/tfv_step.sv
hdl/tfv_result_queue.sv
hdl/text_field_validator_top.sv
test/testbench.sv
